FILE: hw/rtl/pms_pkg.sv
// ----------------------------------------------------------------------------
// Periodic message scheduler package
// Field widths, action codes, slot record layout and controller interface.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int PAYLOAD_BYTES  = 8;

  localparam int ACTION_W  = 3;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int PRIO_W    = 3;
  localparam int GROUP_W   = 18;
  localparam int DEST_W    = 8;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 8 * PAYLOAD_BYTES;
  localparam int BIDX_W    = 3;
  localparam int WVAL_W    = 16;

  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BYTE   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_WORD   = 3'd5;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [GROUP_W-1:0]   group;
    logic [DEST_W-1:0]    dest;
    logic [LEN_W-1:0]     len;
    logic [TIME_W-1:0]    period;
    logic [TIME_W-1:0]    last_sent;
    logic [PAYLOAD_W-1:0] payload;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic idx_clr;
    logic idx_inc;
    logic use_idx;
    logic rd_en;
    logic wr_rmw;
    logic wr_stamp;
    logic set_valid;
    logic clr_valid;
    logic cand_load;
    logic pend_push;
    logic pend_flush;
    logic reply_load;
    logic reply_full;
  } pms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                bus_ready;
    logic                slot_ok;
    logic                idx_valid;
    logic                idx_last;
    logic                due;
    logic                out_free;
    logic                pend_valid;
  } pms_stat_t;

  // Byte-granular mask covering the first n bytes; n past the end covers all.
  function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [PAYLOAD_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      if (LEN_W'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pms_if.sv
// ----------------------------------------------------------------------------
// Periodic message scheduler channels
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface pms_in_if import pms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [TIME_W-1:0]    now_ticks;
  logic                 bus_ready;
  logic [SLOT_W-1:0]    slot;
  logic [PRIO_W-1:0]    prio;
  logic [GROUP_W-1:0]   group_number;
  logic [DEST_W-1:0]    dest_addr;
  logic [LEN_W-1:0]     msg_len;
  logic [TIME_W-1:0]    period;
  logic [PAYLOAD_W-1:0] payload;
  logic [BIDX_W-1:0]    byte_index;
  logic [WVAL_W-1:0]    write_value;

  modport source (
    output valid, action, now_ticks, bus_ready, slot, prio, group_number, dest_addr,
           msg_len, period, payload, byte_index, write_value,
    input  ready
  );
  modport sink (
    input  valid, action, now_ticks, bus_ready, slot, prio, group_number, dest_addr,
           msg_len, period, payload, byte_index, write_value,
    output ready
  );
endinterface

interface pms_out_if import pms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SLOT_W-1:0]    out_slot;
  logic                 table_full;
  logic [PRIO_W-1:0]    out_prio;
  logic [GROUP_W-1:0]   out_group_number;
  logic [DEST_W-1:0]    out_dest;
  logic [LEN_W-1:0]     out_len;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 last;

  modport source (
    output valid, kind, out_slot, table_full, out_prio, out_group_number, out_dest,
           out_len, out_payload, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_slot, table_full, out_prio, out_group_number, out_dest,
           out_len, out_payload, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/pms_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pms_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic message scheduler controller
// Sequences slot scans, read-modify-writes and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_ctrl import pms_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pms_stat_t stat_i,
  output pms_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_START      = 4'd1;
  localparam logic [3:0] S_FIND       = 4'd2;
  localparam logic [3:0] S_RMW_WR     = 4'd3;
  localparam logic [3:0] S_REPLY_OK   = 4'd4;
  localparam logic [3:0] S_REPLY_FULL = 4'd5;
  localparam logic [3:0] S_SCAN       = 4'd6;
  localparam logic [3:0] S_TREAD      = 4'd7;
  localparam logic [3:0] S_TPUSH      = 4'd8;
  localparam logic [3:0] S_TEND       = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_START;
        end
      end

      S_START: begin
        unique case (stat_i.act)
          ACT_TICK: state_d = stat_i.bus_ready ? S_SCAN : S_IDLE;
          ACT_ADD:  state_d = S_FIND;
          ACT_SET, ACT_BYTE, ACT_WORD: begin
            if (stat_i.slot_ok) begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_RMW_WR;
            end else begin
              state_d = S_IDLE;
            end
          end
          ACT_REMOVE: begin
            cmd_o.clr_valid = stat_i.slot_ok;
            state_d         = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end

      // first free slot search, one slot per cycle
      S_FIND: begin
        cmd_o.use_idx = 1'b1;
        if (!stat_i.idx_valid) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_RMW_WR;
        end else if (stat_i.idx_last) begin
          state_d = S_REPLY_FULL;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end

      S_RMW_WR: begin
        cmd_o.use_idx   = (stat_i.act == ACT_ADD);
        cmd_o.wr_rmw    = 1'b1;
        cmd_o.set_valid = (stat_i.act == ACT_ADD) || (stat_i.act == ACT_SET);
        state_d         = (stat_i.act == ACT_ADD) ? S_REPLY_OK : S_IDLE;
      end

      S_REPLY_OK, S_REPLY_FULL: begin
        if (stat_i.out_free) begin
          cmd_o.reply_load = 1'b1;
          cmd_o.reply_full = (state_q == S_REPLY_FULL);
          state_d          = S_IDLE;
        end
      end

      S_SCAN: begin
        cmd_o.use_idx = 1'b1;
        if (stat_i.idx_valid) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_TREAD;
        end else if (stat_i.idx_last) begin
          state_d = S_TEND;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end

      S_TREAD: begin
        cmd_o.use_idx = 1'b1;
        if (stat_i.due) begin
          cmd_o.wr_stamp  = 1'b1;
          cmd_o.cand_load = 1'b1;
          state_d         = S_TPUSH;
        end else if (stat_i.idx_last) begin
          state_d = S_TEND;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN;
        end
      end

      // one result is held back so the final one can carry last
      S_TPUSH: begin
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.pend_push = 1'b1;
          if (stat_i.idx_last) begin
            state_d = S_TEND;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SCAN;
          end
        end
      end

      S_TEND: begin
        if (!stat_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.pend_flush = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pms_dp.sv
// ----------------------------------------------------------------------------
// Periodic message scheduler datapath
// Request registers, slot table, scan index, pending and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_dp import pms_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pms_cmd_t             cmd_i,
  output pms_stat_t                 stat_o,
  input  wire logic [ACTION_W-1:0]  action_i,
  input  wire logic [TIME_W-1:0]    now_ticks_i,
  input  wire logic                 bus_ready_i,
  input  wire logic [SLOT_W-1:0]    slot_i,
  input  wire logic [PRIO_W-1:0]    prio_i,
  input  wire logic [GROUP_W-1:0]   group_number_i,
  input  wire logic [DEST_W-1:0]    dest_addr_i,
  input  wire logic [LEN_W-1:0]     msg_len_i,
  input  wire logic [TIME_W-1:0]    period_i,
  input  wire logic [PAYLOAD_W-1:0] payload_i,
  input  wire logic [BIDX_W-1:0]    byte_index_i,
  input  wire logic [WVAL_W-1:0]    write_value_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic                      kind_o,
  output logic [SLOT_W-1:0]         out_slot_o,
  output logic                      table_full_o,
  output logic [PRIO_W-1:0]         out_prio_o,
  output logic [GROUP_W-1:0]        out_group_number_o,
  output logic [DEST_W-1:0]         out_dest_o,
  output logic [LEN_W-1:0]          out_len_o,
  output logic [PAYLOAD_W-1:0]      out_payload_o,
  output logic                      last_o
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAYLOAD_BYTES);

  // latched request
  logic [ACTION_W-1:0]  act_q;
  logic [TIME_W-1:0]    now_q;
  logic                 bus_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [GROUP_W-1:0]   grp_q;
  logic [DEST_W-1:0]    dest_q;
  logic [LEN_W-1:0]     len_q;
  logic [TIME_W-1:0]    period_q;
  logic [PAYLOAD_W-1:0] pay_q;
  logic [BIDX_W-1:0]    bidx_q;
  logic [WVAL_W-1:0]    wval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q    <= action_i;
      now_q    <= now_ticks_i;
      bus_q    <= bus_ready_i;
      slot_q   <= slot_i;
      prio_q   <= prio_i;
      grp_q    <= group_number_i;
      dest_q   <= dest_addr_i;
      len_q    <= (msg_len_i > MAX_LEN) ? MAX_LEN : msg_len_i;
      period_q <= period_i;
      pay_q    <= payload_i;
      bidx_q   <= byte_index_i;
      wval_q   <= write_value_i;
    end
  end

  // scan index and valid bits
  logic [IW-1:0]         idx_q;
  logic [TASK_SLOTS-1:0] valid_q;
  logic [CW-1:0]         slot_ext;
  logic [IW-1:0]         slot_addr;
  logic [IW-1:0]         addr;

  assign slot_ext  = CW'(slot_q);
  assign slot_addr = IW'(slot_ext);
  assign addr      = cmd_i.use_idx ? idx_q : slot_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_valid) begin
        valid_q[addr] <= 1'b1;
      end else if (cmd_i.clr_valid) begin
        valid_q[addr] <= 1'b0;
      end
    end
  end

  // slot table
  slot_rec_t        rec_rd;
  slot_rec_t        rec_merged;
  slot_rec_t        rec_stamped;
  logic [REC_W-1:0] ram_rdata;
  logic [REC_W-1:0] ram_wdata;
  logic [LEN_W-1:0] hi_pos;

  assign rec_rd    = slot_rec_t'(ram_rdata);
  assign ram_wdata = cmd_i.wr_stamp ? REC_W'(rec_stamped) : REC_W'(rec_merged);
  assign hi_pos    = LEN_W'(bidx_q) + 1'b1;

  always_comb begin
    rec_stamped           = rec_rd;
    rec_stamped.last_sent = now_q;

    rec_merged = rec_rd;
    if (act_q == ACT_ADD || act_q == ACT_SET) begin
      rec_merged.prio      = prio_q;
      rec_merged.group     = grp_q;
      rec_merged.dest      = dest_q;
      rec_merged.len       = len_q;
      rec_merged.period    = period_q;
      rec_merged.last_sent = '0;
    end
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      if ((act_q == ACT_ADD || act_q == ACT_SET) && (LEN_W'(b) < len_q)) begin
        rec_merged.payload[8*b +: 8] = pay_q[8*b +: 8];
      end
      if ((act_q == ACT_BYTE || act_q == ACT_WORD) && (BIDX_W'(b) == bidx_q)) begin
        rec_merged.payload[8*b +: 8] = wval_q[7:0];
      end
      // high byte of a word past the end matches no byte lane and is dropped
      if ((act_q == ACT_WORD) && (LEN_W'(b) == hi_pos)) begin
        rec_merged.payload[8*b +: 8] = wval_q[15:8];
      end
    end
  end

  pms_ram #(
    .WIDTH (REC_W),
    .DEPTH (TASK_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_rmw | cmd_i.wr_stamp),
    .waddr_i (addr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // due test: never sent, or wrapped elapsed time reached the interval
  logic [TIME_W-1:0] elapsed;
  assign elapsed = now_q - rec_rd.last_sent;

  // candidate, pending and output registers
  logic [SLOT_W-1:0]    cand_slot_q, pend_slot_q;
  logic [PRIO_W-1:0]    cand_prio_q, pend_prio_q;
  logic [GROUP_W-1:0]   cand_grp_q, pend_grp_q;
  logic [DEST_W-1:0]    cand_dest_q, pend_dest_q;
  logic [LEN_W-1:0]     cand_len_q, pend_len_q;
  logic [PAYLOAD_W-1:0] cand_pay_q, pend_pay_q;
  logic                 pend_valid_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 out_load;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.reply_load || cmd_i.pend_flush || (cmd_i.pend_push && pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pend_push) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.pend_flush) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_load) begin
      cand_slot_q <= SLOT_W'(idx_q);
      cand_prio_q <= rec_rd.prio;
      cand_grp_q  <= rec_rd.group;
      cand_dest_q <= rec_rd.dest;
      cand_len_q  <= rec_rd.len;
      cand_pay_q  <= rec_rd.payload & byte_mask(rec_rd.len);
    end
    if (cmd_i.pend_push) begin
      pend_slot_q <= cand_slot_q;
      pend_prio_q <= cand_prio_q;
      pend_grp_q  <= cand_grp_q;
      pend_dest_q <= cand_dest_q;
      pend_len_q  <= cand_len_q;
      pend_pay_q  <= cand_pay_q;
    end
    if (cmd_i.reply_load) begin
      kind_o             <= KIND_REPLY;
      out_slot_o         <= cmd_i.reply_full ? '0 : SLOT_W'(idx_q);
      table_full_o       <= cmd_i.reply_full;
      out_prio_o         <= '0;
      out_group_number_o <= '0;
      out_dest_o         <= '0;
      out_len_o          <= '0;
      out_payload_o      <= '0;
      last_o             <= 1'b1;
    end else if (out_load) begin
      kind_o             <= KIND_TX;
      out_slot_o         <= pend_slot_q;
      table_full_o       <= 1'b0;
      out_prio_o         <= pend_prio_q;
      out_group_number_o <= pend_grp_q;
      out_dest_o         <= pend_dest_q;
      out_len_o          <= pend_len_q;
      out_payload_o      <= pend_pay_q;
      last_o             <= cmd_i.pend_flush;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o            = '0;
    stat_o.act        = act_q;
    stat_o.bus_ready  = bus_q;
    stat_o.slot_ok    = slot_ext < CW'(TASK_SLOTS);
    stat_o.idx_valid  = valid_q[idx_q];
    stat_o.idx_last   = (idx_q == IW'(TASK_SLOTS - 1));
    stat_o.due        = (rec_rd.last_sent == '0) || (elapsed >= rec_rd.period);
    stat_o.out_free   = out_free;
    stat_o.pend_valid = pend_valid_q;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_message_scheduler_top.sv
// ----------------------------------------------------------------------------
// Periodic message scheduler
// Table of periodic transmit slots with add, set, remove, payload patch and
// tick-driven transmit requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the slot table sits in a single RAM
// that the controller walks slot by slot. A tick with the bus ready visits
// each slot in turn, reads the occupied ones and stamps and emits the due
// ones, and can stall on the result channel; results come out in slot
// order and the final one carries last. Add searches for the first free
// slot at one slot per cycle, then does a read-modify-write and replies,
// or replies that the table is full. Set and payload writes do a
// read-modify-write of the slot record; remove clears the slot's valid
// bit. A new request is taken while the last result still waits in the
// output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_message_scheduler_top import pms_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pms_in_if.sink    in_i,
  pms_out_if.source out_o
);

  pms_cmd_t  cmd;
  pms_stat_t stat;

  pms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pms_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .action_i           (in_i.action),
    .now_ticks_i        (in_i.now_ticks),
    .bus_ready_i        (in_i.bus_ready),
    .slot_i             (in_i.slot),
    .prio_i             (in_i.prio),
    .group_number_i     (in_i.group_number),
    .dest_addr_i        (in_i.dest_addr),
    .msg_len_i          (in_i.msg_len),
    .period_i           (in_i.period),
    .payload_i          (in_i.payload),
    .byte_index_i       (in_i.byte_index),
    .write_value_i      (in_i.write_value),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .kind_o             (out_o.kind),
    .out_slot_o         (out_o.out_slot),
    .table_full_o       (out_o.table_full),
    .out_prio_o         (out_o.out_prio),
    .out_group_number_o (out_o.out_group_number),
    .out_dest_o         (out_o.out_dest),
    .out_len_o          (out_o.out_len),
    .out_payload_o      (out_o.out_payload),
    .last_o             (out_o.last)
  );

endmodule

`default_nettype wire

FILE: tb/sv/periodic_message_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic message scheduler checker
// Watches the request and result channels, keeps its own copy of the slot
// table, predicts the results of every accepted request and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_checker import pms_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pms_in_if           req_i,
  pms_out_if          rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned expected_left_o
);

  localparam int SLOTS = TASK_SLOTS_DEF;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_W-1:0]    slot;
    logic                 full;
    logic [PRIO_W-1:0]    prio;
    logic [GROUP_W-1:0]   group;
    logic [DEST_W-1:0]    dest;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } sched_result_t;

  sched_result_t expected_results[$];
  sched_result_t want;

  logic                 slot_used   [SLOTS];
  logic [PRIO_W-1:0]    slot_prio   [SLOTS];
  logic [GROUP_W-1:0]   slot_group  [SLOTS];
  logic [DEST_W-1:0]    slot_dest   [SLOTS];
  logic [LEN_W-1:0]     slot_len    [SLOTS];
  logic [TIME_W-1:0]    slot_period [SLOTS];
  logic [TIME_W-1:0]    slot_sent   [SLOTS];
  logic [PAYLOAD_W-1:0] slot_data   [SLOTS];

  function automatic logic [PAYLOAD_W-1:0] len_mask(input logic [LEN_W-1:0] n);
    if (n >= PAYLOAD_BYTES) begin
      return '1;
    end
    return (PAYLOAD_W'(1) << (8 * n)) - PAYLOAD_W'(1);
  endfunction

  function automatic void load_slot(input int s);
    logic [LEN_W-1:0]     n;
    logic [PAYLOAD_W-1:0] m;
    n = (req_i.msg_len > PAYLOAD_BYTES) ? LEN_W'(PAYLOAD_BYTES) : req_i.msg_len;
    m = len_mask(n);
    slot_prio[s]   = req_i.prio;
    slot_group[s]  = req_i.group_number;
    slot_dest[s]   = req_i.dest_addr;
    slot_len[s]    = n;
    slot_period[s] = req_i.period;
    // partial copy: bytes at or past the length keep their old value
    slot_data[s]   = (slot_data[s] & ~m) | (req_i.payload & m);
    slot_used[s]   = 1'b1;
    slot_sent[s]   = '0;
  endfunction

  function automatic void patch_byte(input int s, input int pos, input logic [7:0] val);
    if (pos < PAYLOAD_BYTES) begin
      slot_data[s][8*pos +: 8] = val;
    end
  endfunction

  function automatic void predict_request();
    sched_result_t    r;
    logic [TIME_W-1:0] elapsed;
    int               s;
    int               emitted;
    int               free_slot;
    s = int'(req_i.slot);
    emitted = 0;
    free_slot = -1;
    case (req_i.action)
      ACT_TICK: begin
        if (req_i.bus_ready) begin
          for (int i = 0; i < SLOTS; i++) begin
            elapsed = req_i.now_ticks - slot_sent[i];
            // a zero stamp means never sent, so it is always due
            if (slot_used[i] && (slot_sent[i] == '0 || elapsed >= slot_period[i])) begin
              r = '0;
              r.kind    = KIND_TX;
              r.slot    = SLOT_W'(i);
              r.prio    = slot_prio[i];
              r.group   = slot_group[i];
              r.dest    = slot_dest[i];
              r.len     = slot_len[i];
              r.payload = slot_data[i] & len_mask(slot_len[i]);
              expected_results.push_back(r);
              slot_sent[i] = req_i.now_ticks;
              emitted++;
            end
          end
          if (emitted > 0) begin
            expected_results[expected_results.size() - 1].last = 1'b1;
          end
        end
      end
      ACT_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_used[i]) begin
            free_slot = i;
          end
        end
        r = '0;
        r.kind = KIND_REPLY;
        r.last = 1'b1;
        if (free_slot < 0) begin
          r.full = 1'b1;
        end else begin
          r.slot = SLOT_W'(free_slot);
          load_slot(free_slot);
        end
        expected_results.push_back(r);
      end
      ACT_SET: begin
        load_slot(s);
      end
      ACT_REMOVE: begin
        slot_used[s] = 1'b0;
        slot_sent[s] = '0;
      end
      ACT_BYTE: begin
        patch_byte(s, int'(req_i.byte_index), req_i.write_value[7:0]);
      end
      ACT_WORD: begin
        patch_byte(s, int'(req_i.byte_index), req_i.write_value[7:0]);
        patch_byte(s, int'(req_i.byte_index) + 1, req_i.write_value[15:8]);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    mismatch_count_o++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch(what, got, exp_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      mismatch_count_o = 0;
      expected_left_o  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]   = 1'b0;
        slot_sent[i]   = '0;
        slot_prio[i]   = '0;
        slot_group[i]  = '0;
        slot_dest[i]   = '0;
        slot_len[i]    = '0;
        slot_period[i] = '0;
        slot_data[i]   = '0;
      end
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result slot with nothing expected", 64'(rsp_i.out_slot), '0);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(rsp_i.kind), 64'(want.kind));
          check_field("slot", 64'(rsp_i.out_slot), 64'(want.slot));
          check_field("table full", 64'(rsp_i.table_full), 64'(want.full));
          check_field("priority", 64'(rsp_i.out_prio), 64'(want.prio));
          check_field("group number", 64'(rsp_i.out_group_number), 64'(want.group));
          check_field("destination", 64'(rsp_i.out_dest), 64'(want.dest));
          check_field("length", 64'(rsp_i.out_len), 64'(want.len));
          check_field("payload", rsp_i.out_payload, want.payload);
          check_field("last", 64'(rsp_i.last), 64'(want.last));
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_request();
      end
      expected_left_o = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/periodic_message_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic message scheduler testbench
// Drives directed and random requests (ticks, add, set, remove, byte and
// word patches) with random idling on both channels; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_top_test import pms_pkg::*;;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_CYCLES     = 80;
  localparam int RANDOM_PER_PHASE = 100;

  // actions the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  typedef struct {
    logic [ACTION_W-1:0]  action;
    logic [TIME_W-1:0]    now_ticks;
    logic                 bus_ready;
    logic [SLOT_W-1:0]    slot;
    logic [PRIO_W-1:0]    prio;
    logic [GROUP_W-1:0]   group_number;
    logic [DEST_W-1:0]    dest_addr;
    logic [LEN_W-1:0]     msg_len;
    logic [TIME_W-1:0]    period;
    logic [PAYLOAD_W-1:0] payload;
    logic [BIDX_W-1:0]    byte_index;
    logic [WVAL_W-1:0]    write_value;
  } sched_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned       src_idle_pct = 30;
  int unsigned       snk_idle_pct = 70;
  int unsigned       cycle_count  = 0;
  int unsigned       mismatch_count;
  int unsigned       expected_left;
  logic [TIME_W-1:0] tick_clock   = '0;

  pms_in_if  req_if ();
  pms_out_if rsp_if ();

  periodic_message_scheduler_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  periodic_message_scheduler_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .expected_left_o  (expected_left)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input sched_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.action       <= r.action;
    req_if.now_ticks    <= r.now_ticks;
    req_if.bus_ready    <= r.bus_ready;
    req_if.slot         <= r.slot;
    req_if.prio         <= r.prio;
    req_if.group_number <= r.group_number;
    req_if.dest_addr    <= r.dest_addr;
    req_if.msg_len      <= r.msg_len;
    req_if.period       <= r.period;
    req_if.payload      <= r.payload;
    req_if.byte_index   <= r.byte_index;
    req_if.write_value  <= r.write_value;
    req_if.valid        <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic random_fields(output sched_req_t r);
    r.action       = ACT_TICK;
    r.now_ticks    = $urandom;
    r.bus_ready    = 1'($urandom_range(1));
    r.slot         = SLOT_W'($urandom_range(15));
    r.prio         = PRIO_W'($urandom_range(7));
    r.group_number = GROUP_W'($urandom);
    r.dest_addr    = DEST_W'($urandom);
    r.msg_len      = ($urandom_range(99) < 70) ? LEN_W'($urandom_range(8))
                                                : LEN_W'($urandom_range(15, 9));
    r.payload      = {$urandom, $urandom};
    r.byte_index   = BIDX_W'($urandom_range(7));
    r.write_value  = WVAL_W'($urandom);
    case ($urandom_range(9))
      0, 1:    r.period = $urandom;
      2:       r.period = 32'hFFFF_FFFF - $urandom_range(2);
      3, 4:    r.period = '0;
      default: r.period = $urandom_range(10);
    endcase
  endtask

  task automatic make_random_request(output sched_req_t r);
    int unsigned pick;
    random_fields(r);
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.action    = ACT_TICK;
      r.bus_ready = ($urandom_range(99) < 85);
      case ($urandom_range(19))
        0, 1:    tick_clock = $urandom;
        2:       tick_clock = '0;
        3:       tick_clock = 32'hFFFF_FFFF - $urandom_range(3);
        default: tick_clock = tick_clock + $urandom_range(6);
      endcase
      r.now_ticks = tick_clock;
      // occasional stale time stamp
      if ($urandom_range(99) < 8) begin
        r.now_ticks = tick_clock - $urandom_range(4, 1);
      end
    end else if (pick < 60) begin
      r.action = ACT_ADD;
    end else if (pick < 70) begin
      r.action = ACT_SET;
    end else if (pick < 80) begin
      r.action = ACT_REMOVE;
    end else if (pick < 88) begin
      r.action = ACT_BYTE;
    end else if (pick < 97) begin
      r.action = ACT_WORD;
    end else begin
      r.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
    end
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] now, input logic bus);
    sched_req_t r;
    random_fields(r);
    r.action    = ACT_TICK;
    r.now_ticks = now;
    r.bus_ready = bus;
    send_request(r);
  endtask

  task automatic send_setup(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] s,
                            input logic [PRIO_W-1:0] p, input logic [GROUP_W-1:0] g,
                            input logic [DEST_W-1:0] d, input logic [LEN_W-1:0] n,
                            input logic [TIME_W-1:0] per, input logic [PAYLOAD_W-1:0] data);
    sched_req_t r;
    random_fields(r);
    r.action       = act;
    r.slot         = s;
    r.prio         = p;
    r.group_number = g;
    r.dest_addr    = d;
    r.msg_len      = n;
    r.period       = per;
    r.payload      = data;
    send_request(r);
  endtask

  task automatic send_patch(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] s,
                            input logic [BIDX_W-1:0] idx, input logic [WVAL_W-1:0] val);
    sched_req_t r;
    random_fields(r);
    r.action      = act;
    r.slot        = s;
    r.byte_index  = idx;
    r.write_value = val;
    send_request(r);
  endtask

  initial begin
    sched_req_t r;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_TICK;
    req_if.now_ticks    = '0;
    req_if.bus_ready    = 1'b0;
    req_if.slot         = '0;
    req_if.prio         = '0;
    req_if.group_number = '0;
    req_if.dest_addr    = '0;
    req_if.msg_len      = '0;
    req_if.period       = '0;
    req_if.payload      = '0;
    req_if.byte_index   = '0;
    req_if.write_value  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    send_tick(32'd5, 1'b1);
    send_setup(ACT_ADD, 4'd0, '1, '1, '1, 4'd8, '0, '1);
    send_setup(ACT_ADD, 4'd0, '0, '0, '0, 4'd0, '1, '0);
    send_setup(ACT_ADD, 4'd0, 3'd3, 18'h2AAAA, 8'h55, 4'd15, 32'd3, {$urandom, $urandom});
    send_setup(ACT_SET, 4'd15, 3'd5, 18'h15555, 8'hAA, 4'd3, 32'd2, {$urandom, $urandom});
    send_patch(ACT_BYTE, 4'd15, 3'd0, WVAL_W'($urandom));
    send_patch(ACT_WORD, 4'd15, 3'd7, 16'hFFFF);
    send_patch(ACT_WORD, 4'd15, 3'd2, WVAL_W'($urandom));
    send_patch(ACT_BYTE, 4'd4, 3'd3, WVAL_W'($urandom));
    send_tick(32'd0, 1'b1);
    send_tick(32'd0, 1'b0);
    send_tick(32'd1, 1'b1);
    send_tick(32'd2, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'd3, 1'b1);
    send_patch(ACT_REMOVE, 4'd0, BIDX_W'($urandom), WVAL_W'($urandom));
    send_setup(ACT_ADD, 4'd9, PRIO_W'($urandom), GROUP_W'($urandom), DEST_W'($urandom),
               4'd5, 32'd4, {$urandom, $urandom});
    send_patch(ACT_SPARE_A, 4'd1, BIDX_W'($urandom), WVAL_W'($urandom));
    send_patch(ACT_SPARE_B, 4'd2, BIDX_W'($urandom), WVAL_W'($urandom));
    send_setup(ACT_SET, 4'd2, PRIO_W'($urandom), GROUP_W'($urandom), DEST_W'($urandom),
               4'd8, 32'd1, {$urandom, $urandom});
    send_tick(32'd10, 1'b1);
    send_patch(ACT_REMOVE, 4'd15, BIDX_W'($urandom), WVAL_W'($urandom));
    send_tick(32'd20, 1'b1);
    tick_clock = 32'd20;

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 30;
          snk_idle_pct = 70;
        end
        1: begin
          src_idle_pct = 70;
          snk_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        make_random_request(r);
        send_request(r);
      end
    end
    req_if.valid <= 1'b0;

    while (expected_left != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pms_pkg.sv
hw/rtl/pms_if.sv
hw/rtl/pms_ram.sv
hw/rtl/pms_ctrl.sv
hw/rtl/pms_dp.sv
hw/rtl/periodic_message_scheduler_top.sv
tb/sv/periodic_message_scheduler_checker.sv
tb/sv/periodic_message_scheduler_top_test.sv
